@@ rtl/hpdt_pkg.sv @@
// Package for the heading PD differential-thrust block: types and constants.
// No dependencies.
`default_nettype none
package hpdt_pkg;
    localparam logic [16:0] Q_ONE    = 17'd65536;
    localparam logic [16:0] BAND_060 = 17'd39322;
    localparam logic [16:0] BAND_015 = 17'd9830;
    localparam logic [16:0] BAND_025 = 17'd16384;
    localparam logic [16:0] BAND_055 = 17'd36045;
    localparam logic signed [19:0] DEG_180 = 20'sd46080;
    localparam logic signed [19:0] DEG_360 = 20'sd92160;
    localparam logic [17:0] TIE_LIMIT = 18'd1280;

    localparam logic [1:0] CFG_PDIV   = 2'd0;
    localparam logic [1:0] CFG_DGAIN  = 2'd1;
    localparam logic [1:0] CFG_LSCALE = 2'd2;
    localparam logic [1:0] CFG_RSCALE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_PDIV, ST_DMUL, ST_SUM, ST_SCALE, ST_SCALE2,
        ST_MAPL, ST_DIVL, ST_MAPR, ST_DIVR, ST_DONE
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [17:0] yaw_sample;
        logic [17:0] target_angle;
        logic [16:0] thrust;
    } t_in_word;

    typedef struct packed {
        logic [16:0] left_drive;
        logic [16:0] right_drive;
    } t_out_word;
endpackage
`default_nettype wire

@@ rtl/hpdt_in_if.sv @@
// Input channel interface: valid/ready with the command word.
// Depends on hpdt_pkg.
`default_nettype none
interface hpdt_in_if;
    logic valid;
    logic ready;
    hpdt_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/hpdt_out_if.sv @@
// Output channel interface: valid/ready with the drive word.
// Depends on hpdt_pkg.
`default_nettype none
interface hpdt_out_if;
    logic valid;
    logic ready;
    hpdt_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/hpdt_div.sv @@
// Shared restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing.
`default_nettype none
module hpdt_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [33:0] i_num,
    input  wire  [16:0] i_den,
    output logic        o_busy,
    output logic [33:0] o_quo
);
    logic [33:0] r_quo;
    logic [17:0] r_rem;
    logic [5:0]  r_cnt;
    logic [16:0] r_den;
    logic        r_busy;
    logic [17:0] w_shift;
    logic [18:0] w_diff;

    assign w_shift = {r_rem[16:0], r_quo[33]};
    assign w_diff  = {1'b0, w_shift} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd34;
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_diff[18]) begin
                r_rem <= w_diff[17:0];
                r_quo <= {r_quo[32:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[32:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end
    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

@@ rtl/heading_pd_differential_thrust_top.sv @@
// Top level of the heading PD differential-thrust controller.
// Depends on hpdt_pkg, hpdt_in_if, hpdt_out_if, hpdt_div.
//
//  channel   dir  word
//  s_in      in   req_type, yaw_sample, target_angle, thrust
//  m_out     out  left_drive, right_drive
//  cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data
//
// Yaw update: stored in the yaw register on acceptance. Heading command:
// three passes through the single bit-serial divider (p term, left map,
// right map) plus eight other steps. Synchronous active-low reset restores
// state, configuration and output valid and clears yaw and last error.
// Input is ready only in idle; a finished word waits in the output register
// and the next command's last step stalls on it.
`default_nettype none
module heading_pd_differential_thrust_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [1:0] i_cfg_idx,
    input  wire [16:0] i_cfg_data,
    hpdt_in_if.sink    s_in,
    hpdt_out_if.source m_out
);
    hpdt_pkg::t_state r_state, n_state;
    logic [15:0] r_pdiv, r_dgain;
    logic [16:0] r_lscale, r_rscale;
    logic signed [17:0] r_yaw, r_last, r_e;
    logic signed [17:0] r_tgt;
    logic [16:0] r_thr;
    logic signed [35:0] r_p, r_d;
    logic signed [37:0] r_side;
    logic [16:0] r_l, r_r, r_lo, r_ro;
    logic [16:0] r_lout, r_rout;
    logic        r_ovalid, r_pos, r_rneg;
    logic        w_start;
    logic [33:0] w_num;
    logic [16:0] w_den;
    logic        w_busy;
    logic [33:0] w_quo;
    logic signed [19:0] w_e0, w_e1;
    logic [17:0] w_e18, w_eabs;
    logic [17:0] w_mag;
    logic [16:0] w_den_m;
    logic [16:0] w_ul, w_ur;
    logic [16:0] w_lo_l, w_hi_l, w_lo_r, w_hi_r;
    logic [17:0] w_scl;
    logic        w_gt, w_load;

    // Scaled side, truncated toward zero. Bit 17 flags a nonzero negative
    // result; a negative result maps like zero, so the value part is zero.
    function automatic logic [17:0] scl(input logic signed [37:0] v,
                                        input logic [16:0] s);
        logic signed [55:0] m;
        logic [55:0] a;
        m = 56'(v) * 56'(signed'({1'b0, s}));
        a = m[55] ? 56'(-m) : 56'(m);
        a = a >> 16;
        if (m[55]) return {(a != 56'd0), 17'd0};
        return {1'b0, a[16:0]};
    endfunction

    function automatic logic [16:0] fin(input logic [33:0] q,
                                        input logic [16:0] lo,
                                        input logic [16:0] hi);
        logic [34:0] r;
        r = 35'(lo) + 35'(q);
        if (r_thr >= hpdt_pkg::Q_ONE) return lo;
        if (hi < lo) return hi;
        if (r > 35'(hi)) return hi;
        return r[16:0];
    endfunction

    hpdt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_busy(w_busy), .o_quo(w_quo)
    );

    assign w_den_m = hpdt_pkg::Q_ONE - r_thr;
    assign w_ul = (r_l > w_den_m) ? w_den_m : r_l;
    assign w_ur = (r_r > w_den_m) ? w_den_m : r_r;
    assign w_e0 = 20'(r_tgt) - 20'(r_yaw);
    always_comb begin
        if (w_e0 > hpdt_pkg::DEG_180) w_e1 = w_e0 - hpdt_pkg::DEG_360;
        else if (w_e0 < -hpdt_pkg::DEG_180) w_e1 = w_e0 + hpdt_pkg::DEG_360;
        else w_e1 = w_e0;
    end
    assign w_e18 = w_e1[17:0];
    assign w_eabs = w_e18[17] ? 18'(-w_e18) : w_e18;
    assign w_mag = r_e[17] ? 18'(-r_e) : 18'(r_e);
    assign w_scl = scl(r_side, r_pos ? r_lscale : r_rscale);

    // L > R: one of them is zero, the other is the active side.
    assign w_gt = r_pos ? (r_l != 17'd0) : r_rneg;

    always_comb begin
        w_lo_l = hpdt_pkg::BAND_060;
        w_hi_l = w_gt ? hpdt_pkg::Q_ONE : hpdt_pkg::BAND_025;
        w_hi_r = w_gt ? hpdt_pkg::BAND_025 : hpdt_pkg::Q_ONE;
        w_lo_r = w_gt ? hpdt_pkg::BAND_015 : hpdt_pkg::BAND_055;
    end

    // Divider operand select; p divides |e|<<16, maps divide u*(hi-lo).
    always_comb begin
        w_start = 1'b0;
        w_num   = '0;
        w_den   = w_den_m;
        unique case (r_state)
            hpdt_pkg::ST_ERR: begin
                w_start = 1'b1;
                w_num   = {w_eabs, 16'b0};
                w_den   = (r_pdiv == 16'd0) ? 17'd1 : {1'b0, r_pdiv};
            end
            hpdt_pkg::ST_MAPL: begin
                w_start = 1'b1;
                w_num   = 34'(w_ul) * 34'(w_hi_l - w_lo_l);
            end
            hpdt_pkg::ST_MAPR: begin
                w_start = 1'b1;
                w_num   = 34'(w_ur) * 34'(w_hi_r - w_lo_r);
            end
            default: ;
        endcase
    end

    // Final step loads the output register once the previous word is gone.
    assign w_load = (r_state == hpdt_pkg::ST_DONE) && (!r_ovalid || m_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpdt_pkg::ST_IDLE:
                if (s_in.valid && s_in.data.req_type)
                    n_state = hpdt_pkg::ST_ERR;
            hpdt_pkg::ST_ERR:    n_state = hpdt_pkg::ST_PDIV;
            hpdt_pkg::ST_PDIV:   if (!w_busy) n_state = hpdt_pkg::ST_DMUL;
            hpdt_pkg::ST_DMUL:   n_state = hpdt_pkg::ST_SUM;
            hpdt_pkg::ST_SUM:    n_state = hpdt_pkg::ST_SCALE;
            hpdt_pkg::ST_SCALE:  n_state = hpdt_pkg::ST_SCALE2;
            hpdt_pkg::ST_SCALE2: n_state = hpdt_pkg::ST_MAPL;
            hpdt_pkg::ST_MAPL:   n_state = hpdt_pkg::ST_DIVL;
            hpdt_pkg::ST_DIVL:   if (!w_busy) n_state = hpdt_pkg::ST_MAPR;
            hpdt_pkg::ST_MAPR:   n_state = hpdt_pkg::ST_DIVR;
            hpdt_pkg::ST_DIVR:   if (!w_busy) n_state = hpdt_pkg::ST_DONE;
            hpdt_pkg::ST_DONE:   if (w_load) n_state = hpdt_pkg::ST_IDLE;
            default:             n_state = hpdt_pkg::ST_IDLE;
        endcase
    end

    assign s_in.ready = (r_state == hpdt_pkg::ST_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.data.left_drive  = r_lout;
    assign m_out.data.right_drive = r_rout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hpdt_pkg::ST_IDLE;
            r_pdiv   <= 16'd2560;
            r_dgain  <= '0;
            r_lscale <= hpdt_pkg::Q_ONE;
            r_rscale <= hpdt_pkg::Q_ONE;
            r_yaw    <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hpdt_pkg::CFG_PDIV:   r_pdiv   <= i_cfg_data[15:0];
                    hpdt_pkg::CFG_DGAIN:  r_dgain  <= i_cfg_data[15:0];
                    hpdt_pkg::CFG_LSCALE: r_lscale <= i_cfg_data;
                    hpdt_pkg::CFG_RSCALE: r_rscale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load) r_ovalid <= 1'b1;
            else if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                hpdt_pkg::ST_IDLE: if (s_in.valid && s_in.ready) begin
                    if (!s_in.data.req_type) r_yaw <= s_in.data.yaw_sample;
                    r_tgt <= s_in.data.target_angle;
                    r_thr <= s_in.data.thrust;
                end
                hpdt_pkg::ST_ERR: r_e <= w_e18;
                hpdt_pkg::ST_DMUL: begin
                    r_p    <= r_e[17] ? -36'(w_quo) : 36'(w_quo);
                    r_d    <= 36'(signed'({1'b0, r_dgain})) * 36'(19'(r_e) - 19'(r_last));
                    r_last <= r_e;
                end
                hpdt_pkg::ST_SUM: begin
                    r_pos  <= !r_e[17] && (r_e != 0);
                    r_side <= !r_e[17] && (r_e != 0) ? 38'(r_p + r_d)
                                                     : 38'(-r_p - r_d);
                end
                hpdt_pkg::ST_SCALE:
                    if (r_side > 38'sd65536) r_side <= 38'sd65536;
                hpdt_pkg::ST_SCALE2: begin
                    // truncate toward zero; side may be very negative
                    if (r_pos) begin
                        r_l    <= w_scl[16:0];
                        r_r    <= '0;
                        r_rneg <= 1'b0;
                    end else begin
                        r_r    <= w_scl[16:0];
                        r_l    <= '0;
                        r_rneg <= w_scl[17];
                    end
                end
                hpdt_pkg::ST_MAPL: ;
                hpdt_pkg::ST_DIVL: if (!w_busy) r_lo <= fin(w_quo, w_lo_l, w_hi_l);
                hpdt_pkg::ST_DIVR: if (!w_busy) r_ro <= fin(w_quo, w_lo_r, w_hi_r);
                hpdt_pkg::ST_DONE: if (w_load) begin
                    if (w_mag < hpdt_pkg::TIE_LIMIT) begin
                        r_lout <= w_gt ? r_lo : r_ro;
                        r_rout <= w_gt ? r_lo : r_ro;
                    end else begin
                        r_lout <= r_lo;
                        r_rout <= r_ro;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != hpdt_pkg::ST_IDLE) |-> !s_in.ready) else $error("accept while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpdt_pkg::ST_DONE) |=> r_ovalid) else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpdt_pkg::ST_ERR) |=> w_busy) else $error("divider idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(m_out.data)))
        else $error("held word changed");
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for heading_pd_differential_thrust_top: directed table plus random commands,
// checked against a behavioral PD/band-map predictor. Depends on hpdt_pkg, the interfaces and the top.
`timescale 1ns / 1ps
module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;

    hpdt_in_if  s_in ();
    hpdt_out_if m_out ();

    heading_pd_differential_thrust_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_in      (s_in),
        .m_out     (m_out)
    );

    // predictor state and register copy
    longint    pdiv_q, dgain_q, lscale_q, rscale_q;
    longint    yaw_q, prev_err_q;
    hpdt_pkg::t_out_word drive_q[$];
    int        mismatches;
    longint    cycles;
    bit        rand_out_stall;
    int        out_gap;

    function automatic longint sx18(longint x);
        longint v;
        v = x & 64'h3FFFF;
        if (v & 64'h20000) v -= 64'h40000;
        return v;
    endfunction

    function automatic longint band(longint v, longint thr, longint lo, longint hi);
        longint den, u, r;
        if (thr >= 65536) return lo;
        den = 65536 - thr;
        u = v < 0 ? 0 : (v > den ? den : v);
        r = lo + (u * (hi - lo)) / den;
        if (r < lo) r = lo;
        else if (r > hi) r = hi;
        return r;
    endfunction

    // updates state; returns 1 and the drive word for a heading command
    function automatic bit predict_drive(hpdt_pkg::t_in_word w,
                                         output hpdt_pkg::t_out_word o);
        longint e, p, d, lft, rgt, lo_o, ro_o, mag, pd, thr;
        o = '0;
        thr = w.thrust;
        if (!w.req_type) begin
            yaw_q = sx18(w.yaw_sample);
            return 0;
        end
        pd = pdiv_q == 0 ? 1 : pdiv_q;
        e = sx18(w.target_angle) - yaw_q;
        if (e > 46080) e -= 92160;
        else if (e < -46080) e += 92160;
        e = sx18(e);
        d = dgain_q * (e - prev_err_q);
        prev_err_q = e;
        p = (e * 65536) / pd;
        lft = 0;
        rgt = 0;
        if (e > 0) begin
            lft = p + d;
            if (lft > 65536) lft = 65536;
            lft = (lft * lscale_q) / 65536;
        end else begin
            rgt = -p - d;
            if (rgt > 65536) rgt = 65536;
            rgt = (rgt * rscale_q) / 65536;
        end
        mag = e < 0 ? -e : e;
        if (lft > rgt) begin
            lo_o = band(lft, thr, hpdt_pkg::BAND_060, 65536);
            ro_o = band(rgt, thr, hpdt_pkg::BAND_015, hpdt_pkg::BAND_025);
            if (mag < 1280) ro_o = lo_o;
        end else begin
            lo_o = band(lft, thr, hpdt_pkg::BAND_060, hpdt_pkg::BAND_025);
            ro_o = band(rgt, thr, hpdt_pkg::BAND_055, 65536);
            if (mag < 1280) lo_o = ro_o;
        end
        o.left_drive  = lo_o[16:0];
        o.right_drive = ro_o[16:0];
        return 1;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output side: random stall when rand_out_stall is set, check on accept
    always @(posedge i_clk) begin
        hpdt_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            m_out.ready <= 1'b0;
            out_gap     <= 0;
        end else begin
            if (m_out.valid && m_out.ready) begin
                if (drive_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", m_out.data);
                end else begin
                    exp_w = drive_q.pop_front();
                    if (m_out.data.left_drive !== exp_w.left_drive ||
                        m_out.data.right_drive !== exp_w.right_drive) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive mismatch: exp L=%0d R=%0d got L=%0d R=%0d",
                                     exp_w.left_drive, exp_w.right_drive,
                                     m_out.data.left_drive, m_out.data.right_drive);
                    end
                end
            end
            if (out_gap != 0) begin
                m_out.ready <= 1'b0;
                out_gap     <= out_gap - 1;
            end else begin
                m_out.ready <= 1'b1;
                if (rand_out_stall)
                    out_gap <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 60))
                                                            : int'($urandom_range(0, 2));
            end
        end
    end

    // caller drops the write enable after the last write
    task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            hpdt_pkg::CFG_PDIV:   pdiv_q   = val[15:0];
            hpdt_pkg::CFG_DGAIN:  dgain_q  = val[15:0];
            hpdt_pkg::CFG_LSCALE: lscale_q = val;
            hpdt_pkg::CFG_RSCALE: rscale_q = val;
            default: ;
        endcase
    endtask

    task automatic drain_idle();
        s_in.valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // valid stays up after an accept unless a gap follows
    task automatic send_word(hpdt_pkg::t_in_word w, bit gaps);
        hpdt_pkg::t_out_word o;
        int g;
        if (gaps) begin
            g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            if (g != 0) begin
                s_in.valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        s_in.valid <= 1'b1;
        s_in.data  <= w;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        if (predict_drive(w, o)) drive_q.push_back(o);
    endtask

    function automatic hpdt_pkg::t_in_word rand_word(bit cmd);
        hpdt_pkg::t_in_word w;
        int k;
        w.req_type = cmd;
        k = $urandom_range(0, 9);
        w.yaw_sample   = (k == 0) ? 18'($urandom) : 18'($urandom_range(0, 184320) - 92160);
        w.target_angle = (k == 1) ? 18'($urandom) : 18'($urandom_range(0, 184320) - 92160);
        if ($urandom_range(0, 3) == 0)
            w.target_angle = 18'(yaw_q + $urandom_range(0, 4000) - 2000);
        k = $urandom_range(0, 9);
        w.thrust = (k == 0) ? 17'd65536 : (k == 1) ? 17'($urandom) : 17'($urandom_range(0, 65535));
        return w;
    endfunction

    typedef struct {
        logic        req;
        int          yaw;
        int          tgt;
        int          thr;
        bit          known;
        logic [16:0] el;
        logic [16:0] er;
    } t_row;

    t_row rows[] = '{
        '{1'b1, 0, 0, 0, 1'b1, 17'd36045, 17'd36045},        // zero error after reset
        '{1'b1, 0, 25600, 65536, 1'b1, 17'd39322, 17'd9830}, // full thrust, left active
        '{1'b1, 0, -25600, 65536, 1'b1, 17'd39322, 17'd36045},
        '{1'b0, 92160, 0, 0, 1'b0, 0, 0},
        '{1'b1, 0, -92160, 0, 1'b0, 0, 0},
        '{1'b1, 0, 92160, 1000, 1'b0, 0, 0},
        '{1'b0, -92160, 0, 0, 1'b0, 0, 0},
        '{1'b1, 0, 92160, 30000, 1'b0, 0, 0},
        '{1'b1, 0, -131072, 131071, 1'b0, 0, 0},
        '{1'b0, 131071, 0, 0, 1'b0, 0, 0},
        '{1'b1, 0, -131072, 5, 1'b0, 0, 0},
        '{1'b0, 0, 0, 0, 1'b0, 0, 0},
        '{1'b1, 0, 1279, 0, 1'b0, 0, 0},
        '{1'b1, 0, -1279, 0, 1'b0, 0, 0},
        '{1'b1, 0, 1280, 40000, 1'b0, 0, 0},
        '{1'b1, 0, 46081, 65535, 1'b0, 0, 0},
        '{1'b1, 0, -46081, 0, 1'b0, 0, 0}
    };

    initial begin
        hpdt_pkg::t_in_word w;
        hpdt_pkg::t_out_word o;
        int n;
        cycles = 0;
        mismatches = 0;
        rand_out_stall = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_in.valid = 0;
        s_in.data = '0;
        pdiv_q = 2560; dgain_q = 0; lscale_q = 65536; rscale_q = 65536;
        yaw_q = 0; prev_err_q = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            w.req_type     = rows[i].req;
            w.yaw_sample   = 18'(rows[i].yaw);
            w.target_angle = 18'(rows[i].tgt);
            w.thrust       = 17'(rows[i].thr);
            n = drive_q.size();
            send_word(w, 1'b0);
            if (rows[i].known && drive_q.size() > n) begin
                o.left_drive = rows[i].el;
                o.right_drive = rows[i].er;
                if (o !== drive_q[$]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: exp L=%0d R=%0d predicted L=%0d R=%0d",
                                 i, o.left_drive, o.right_drive,
                                 drive_q[$].left_drive, drive_q[$].right_drive);
                end
            end
        end
        drain_idle();

        rand_out_stall = 1;
        // settings phases, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin cfg_write(hpdt_pkg::CFG_PDIV, 17'd0);
                         cfg_write(hpdt_pkg::CFG_DGAIN, 17'd0); end
                1: begin cfg_write(hpdt_pkg::CFG_PDIV, 17'd65535);
                         cfg_write(hpdt_pkg::CFG_DGAIN, 17'd65535); end
                2: begin cfg_write(hpdt_pkg::CFG_PDIV, 17'd1);
                         cfg_write(hpdt_pkg::CFG_LSCALE, 17'd0);
                         cfg_write(hpdt_pkg::CFG_RSCALE, 17'd0); end
                3: begin cfg_write(hpdt_pkg::CFG_PDIV, 17'd2560);
                         cfg_write(hpdt_pkg::CFG_DGAIN, 17'd16);
                         cfg_write(hpdt_pkg::CFG_LSCALE, 17'd65536);
                         cfg_write(hpdt_pkg::CFG_RSCALE, 17'd131071); end
                default: begin
                    cfg_write(hpdt_pkg::CFG_PDIV, 17'($urandom_range(1, 65535)));
                    cfg_write(hpdt_pkg::CFG_DGAIN, 17'($urandom_range(0, 300)));
                    cfg_write(hpdt_pkg::CFG_LSCALE, 17'($urandom_range(0, 65536)));
                    cfg_write(hpdt_pkg::CFG_RSCALE, 17'($urandom_range(0, 65536)));
                end
            endcase
            i_cfg_we <= 1'b0;
            for (int k = 0; k < 230; k++) begin
                w = rand_word($urandom_range(0, 2) != 0);
                send_word(w, k % 50 < 40);
            end
            drain_idle();
        end

        drain_idle();
        if (mismatches == 0 && drive_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/hpdt_pkg.sv
rtl/hpdt_in_if.sv
rtl/hpdt_out_if.sv
rtl/hpdt_div.sv
rtl/heading_pd_differential_thrust_top.sv
bench/testbench.sv
